[src/sgf_pkg.sv]
// ----------------------------------------------------------------------------
// sgf_pkg
// Shared types and constants of the six-axis linear-fit smoother.
// ----------------------------------------------------------------------------
package sgf_pkg;

    localparam int TAP_COUNT  = 8;
    localparam int AXIS_COUNT = 6;
    localparam int STAGES     = 5;

    // Stage positions in the valid/ready chain
    localparam int ST_HIST = 0;
    localparam int ST_SUM  = 1;
    localparam int ST_MAG  = 2;
    localparam int ST_QUO  = 3;
    localparam int ST_RES  = 4;

    // Weights indexed by age: entry 0 is the newest sample, entry 7 the oldest.
    // Each weight is taken over 12.
    localparam logic signed [3:0] TAP_WEIGHT [TAP_COUNT] = '{
        -4'sd2, -4'sd1, 4'sd0, 4'sd1, 4'sd2, 4'sd3, 4'sd4, 4'sd5
    };

    typedef struct packed {
        logic hist;
        logic sum;
        logic mag;
        logic quo;
        logic res;
    } stage_load_t;

endpackage

[src/sgf_ctrl.sv]
// ----------------------------------------------------------------------------
// sgf_ctrl
// Valid/ready chain of the smoothing pipeline; issues stage load enables.
// ----------------------------------------------------------------------------
module sgf_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    output logic                 out_valid,
    input  logic                 out_stall,
    output sgf_pkg::stage_load_t load
);

    logic [sgf_pkg::STAGES-1:0] valid_reg;
    logic [sgf_pkg::STAGES-1:0] valid_next;
    logic [sgf_pkg::STAGES-1:0] src_valid;
    logic [sgf_pkg::STAGES-1:0] load_vec;
    logic [sgf_pkg::STAGES:0]   rdy;

    always_comb
    begin
        // a stage can take a transaction when empty or when its content moves on
        rdy[sgf_pkg::STAGES] = !out_stall;
        for (int k = sgf_pkg::STAGES - 1; k >= 0; k--)
        begin
            rdy[k] = !valid_reg[k] || rdy[k + 1];
        end
        src_valid = {valid_reg[sgf_pkg::STAGES-2:0], in_valid};
        for (int k = 0; k < sgf_pkg::STAGES; k++)
        begin
            load_vec[k]   = src_valid[k] && rdy[k];
            valid_next[k] = rdy[k] ? src_valid[k] : valid_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign load.hist = load_vec[sgf_pkg::ST_HIST];
    assign load.sum  = load_vec[sgf_pkg::ST_SUM];
    assign load.mag  = load_vec[sgf_pkg::ST_MAG];
    assign load.quo  = load_vec[sgf_pkg::ST_QUO];
    assign load.res  = load_vec[sgf_pkg::ST_RES];

    assign in_stall  = !rdy[0];
    assign out_valid = valid_reg[sgf_pkg::ST_RES];

endmodule

[src/sgf_lane.sv]
// ----------------------------------------------------------------------------
// sgf_lane
// One axis: 8-entry history line, weighted sum, divide by 12, saturate.
// ----------------------------------------------------------------------------
module sgf_lane
#(
    parameter int SAMPLE_BITS = 24
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  sgf_pkg::stage_load_t          load,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    output logic signed [SAMPLE_BITS-1:0] smoothed
);

    // |sum| < 18 * 2^(SAMPLE_BITS-1): positive weights add to 15, negative to 3
    localparam int ACC_W   = SAMPLE_BITS + 5;
    localparam int MAG_W   = SAMPLE_BITS + 4;
    localparam int N_W     = MAG_W - 2;
    localparam int SHIFT   = N_W + 2;
    localparam int RECIP_W = N_W + 1;
    localparam int PROD_W  = N_W + RECIP_W;
    // ceil(2^SHIFT / 3), exact floor division by 3 for N_W-bit operands
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << SHIFT) / 64'd3) + 64'd1);
    localparam logic [SAMPLE_BITS-1:0] POS_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic [SAMPLE_BITS-1:0] NEG_MAG = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    logic signed [SAMPLE_BITS-1:0] hist_reg [sgf_pkg::TAP_COUNT];
    logic signed [ACC_W-1:0]       sum_reg;
    logic signed [ACC_W-1:0]       sum_next;
    logic [N_W-1:0]                quarter_reg;
    logic                          mag_neg_reg;
    logic [ACC_W-1:0]              abs_sum;
    logic [SAMPLE_BITS-1:0]        quo_reg;
    logic                          quo_neg_reg;
    logic [PROD_W-1:0]             prod;
    logic [SAMPLE_BITS-1:0]        res_next;
    logic [SAMPLE_BITS-1:0]        res_reg;

    // history line: entry 0 newest
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < sgf_pkg::TAP_COUNT; j++)
            begin
                hist_reg[j] <= '0;
            end
        end
        else if (load.hist)
        begin
            hist_reg[0] <= sample;
            for (int j = 1; j < sgf_pkg::TAP_COUNT; j++)
            begin
                hist_reg[j] <= hist_reg[j - 1];
            end
        end
    end

    always_comb
    begin
        sum_next = '0;
        for (int j = 0; j < sgf_pkg::TAP_COUNT; j++)
        begin
            sum_next = sum_next
                     + ACC_W'(hist_reg[j]) * ACC_W'(sgf_pkg::TAP_WEIGHT[j]);
        end
    end

    // magnitude / 4, then / 3 by reciprocal: truncation toward zero
    assign abs_sum = sum_reg[ACC_W-1] ? ACC_W'(-sum_reg) : ACC_W'(sum_reg);
    assign prod    = PROD_W'(quarter_reg) * PROD_W'(RECIP);

    always_comb
    begin
        if (!quo_neg_reg)
        begin
            res_next = (quo_reg > POS_MAX) ? POS_MAX : quo_reg;
        end
        else
        begin
            res_next = (quo_reg > NEG_MAG) ? NEG_MAG : SAMPLE_BITS'(-quo_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load.sum)
        begin
            sum_reg <= sum_next;
        end
        if (load.mag)
        begin
            quarter_reg <= abs_sum[MAG_W-1:2];
            mag_neg_reg <= sum_reg[ACC_W-1];
        end
        if (load.quo)
        begin
            quo_reg     <= prod[SHIFT +: SAMPLE_BITS];
            quo_neg_reg <= mag_neg_reg;
        end
        if (load.res)
        begin
            res_reg <= res_next;
        end
    end

    assign smoothed = signed'(res_reg);

endmodule

[src/six_axis_linear_fit_smoother_top.sv]
// ----------------------------------------------------------------------------
// six_axis_linear_fit_smoother_top
// Six-axis 8-tap linear-fit smoother, weights 5..-2 over 12, saturated output.
// ----------------------------------------------------------------------------
// Accepted inputs pass the hist, sum, mag, quo and res registers to out_valid.
// Throughput: one transaction per cycle while out_stall is low; five register
// stages with valid/stall per stage let input continue while a result waits.
// Reset: rst_n clears stage valids and all histories to zero.
module six_axis_linear_fit_smoother_top
#(
    parameter int SAMPLE_BITS = 24
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [SAMPLE_BITS-1:0] roll_in,
    input  logic signed [SAMPLE_BITS-1:0] pitch_in,
    input  logic signed [SAMPLE_BITS-1:0] yaw_in,
    input  logic signed [SAMPLE_BITS-1:0] heave_in,
    input  logic signed [SAMPLE_BITS-1:0] sway_in,
    input  logic signed [SAMPLE_BITS-1:0] surge_in,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [SAMPLE_BITS-1:0] roll_smoothed,
    output logic signed [SAMPLE_BITS-1:0] pitch_smoothed,
    output logic signed [SAMPLE_BITS-1:0] yaw_smoothed,
    output logic signed [SAMPLE_BITS-1:0] heave_smoothed,
    output logic signed [SAMPLE_BITS-1:0] sway_smoothed,
    output logic signed [SAMPLE_BITS-1:0] surge_smoothed
);

    sgf_pkg::stage_load_t          load;
    logic signed [SAMPLE_BITS-1:0] axis_in  [sgf_pkg::AXIS_COUNT];
    logic signed [SAMPLE_BITS-1:0] axis_out [sgf_pkg::AXIS_COUNT];

    sgf_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .load      (load)
    );

    assign axis_in[0] = roll_in;
    assign axis_in[1] = pitch_in;
    assign axis_in[2] = yaw_in;
    assign axis_in[3] = heave_in;
    assign axis_in[4] = sway_in;
    assign axis_in[5] = surge_in;

    for (genvar a = 0; a < sgf_pkg::AXIS_COUNT; a++)
    begin : g_lane
        sgf_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .load     (load),
            .sample   (axis_in[a]),
            .smoothed (axis_out[a])
        );
    end

    assign roll_smoothed  = axis_out[0];
    assign pitch_smoothed = axis_out[1];
    assign yaw_smoothed   = axis_out[2];
    assign heave_smoothed = axis_out[3];
    assign sway_smoothed  = axis_out[4];
    assign surge_smoothed = axis_out[5];

endmodule

[src/sgf_checker.sv]
// ----------------------------------------------------------------------------
// sgf_checker
// Port-level checks of the smoother, bound to the top level.
// ----------------------------------------------------------------------------
module sgf_checker
#(
    parameter int SAMPLE_BITS = 24
)
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_stall,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic signed [SAMPLE_BITS-1:0] roll_smoothed,
    input logic signed [SAMPLE_BITS-1:0] surge_smoothed
);

    // a held result keeps its value
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(roll_smoothed)
                                   && $stable(surge_smoothed))
        else $error("held result changed");

    // input backs up only when the whole pipeline is full behind a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled with room in pipeline");

    // no result may appear straight out of reset
    assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("result valid after reset");

    // a full pipeline whose result stays stalled keeps the input stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall ##1 out_stall |-> in_stall)
        else $error("input released while result still stalled");

endmodule

bind six_axis_linear_fit_smoother_top sgf_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_sgf_checker
(
    .clk            (clk),
    .rst_n          (rst_n),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .roll_smoothed  (roll_smoothed),
    .surge_smoothed (surge_smoothed)
);
